// ===== rtl/bah_pkg.sv =====
// Shared constants, register indexes and the channel averaging function.
`timescale 1ns / 1ps

package bah_pkg;

   localparam int PIXEL_W        = 32;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = PIXEL_W / CHAN_W;
   localparam int GEOM_W         = 13;
   localparam int ROW_W          = 12;
   localparam int MAX_HEIGHT     = 4096;
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int CSR_IDX_W      = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 4'd0,
      REG_IMAGE_HEIGHT = 4'd1
   } csr_reg_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Rounded mean of four pixels, per 8-bit channel: (a+b+c+d+2)>>2.
   function automatic pixel_type box4(input pixel_type a, input pixel_type b,
                                      input pixel_type c, input pixel_type d);
      pixel_type         res;
      logic [CHAN_W+1:0] sum;
      res = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum = {2'b00, a[ch*CHAN_W +: CHAN_W]} + {2'b00, b[ch*CHAN_W +: CHAN_W]}
             + {2'b00, c[ch*CHAN_W +: CHAN_W]} + {2'b00, d[ch*CHAN_W +: CHAN_W]}
             + (CHAN_W+2)'(2);
         res[ch*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
      end
      return res;
   endfunction

endpackage

// ===== rtl/bah_line_bank.sv =====
// One bank of the line store: single write port, one registered read port.
`timescale 1ns / 1ps

module bah_line_bank #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  bah_pkg::pixel_type     wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output bah_pkg::pixel_type     rd_data
);
   import bah_pkg::*;

   pixel_type mem_ff [DEPTH];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/box_average_halve_argb.sv =====
// 2x2 box-filter downsampler for packed four-channel pixels, top level.
`timescale 1ns / 1ps

// Accepts one pixel per clock in raster order while req_stall is low and
// returns the rounded 2x2 mean of each block, one result per column pair of
// each odd row (an odd last column or row pairs with itself). A result passes
// two registers after the pixel that completes its block: the line store read
// and the averaging stage each take one register. The even row is kept in two
// banks of ceil(MAX_WIDTH/2) words, split by column parity, so both upper
// pixels of a pair are read together at the same address. The store needs no
// clearing pass and the block accepts pixels once reset is released.
// Geometry registers are written through the csr_ port, which is always ready.

module box_average_halve_argb #(
   parameter int MAX_WIDTH = bah_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bah_pkg::PIXEL_W-1:0]   req_pixel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bah_pkg::PIXEL_W-1:0]   rsp_pixel_out,
   output logic                          rsp_row_end,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bah_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bah_pkg::GEOM_W-1:0]    csr_data
);
   import bah_pkg::*;

   localparam int XW      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int BANK_D  = (MAX_WIDTH + 1) / 2;
   localparam int AW      = (BANK_D > 1) ? $clog2(BANK_D) : 1;
   localparam int LW      = (XW + 1 > GEOM_W) ? XW + 1 : GEOM_W;

   // Geometry registers
   logic [GEOM_W-1:0] image_width_ff;
   logic [GEOM_W-1:0] image_height_ff;

   // Frame position and pair state
   logic [XW-1:0]     col_ff,  col_in;
   logic [ROW_W-1:0]  row_ff,  row_in;
   pixel_type         left_ff;

   // Stage 1: item waiting for its average
   logic              s1_valid_ff;
   pixel_type         s1_px_ff;
   pixel_type         s1_first_ff;
   logic              s1_odd_row_ff;
   logic              s1_odd_col_ff;
   logic              s1_last_col_ff;
   logic              s1_last_row_ff;

   // Result register
   logic              out_valid_ff;
   pixel_type         out_pixel_ff;
   logic              out_row_end_ff;
   logic              out_frame_end_ff;

   logic              accept;
   logic              out_free;
   logic              s1_move;
   logic [LW-1:0]     width_ext;
   logic [LW-1:0]     last_col_idx;
   logic [GEOM_W-1:0] last_row_idx;
   logic              last_col;
   logic              last_row;
   logic              odd_col;
   logic              odd_row;
   logic              emit;
   pixel_type         first_px;
   logic [AW-1:0]     pair_addr;
   logic              wr_even, wr_odd;
   pixel_type         upper_even, upper_odd;
   pixel_type         up_p, up_q, avg_p, avg_q;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= GEOM_W'(1);
         image_height_ff <= GEOM_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp geometry: zero acts as one, oversize acts as the limit.
   always_comb begin
      width_ext = LW'(image_width_ff);
      if (width_ext == '0) begin
         last_col_idx = '0;
      end else if (width_ext > LW'(MAX_WIDTH)) begin
         last_col_idx = LW'(MAX_WIDTH - 1);
      end else begin
         last_col_idx = width_ext - LW'(1);
      end
      if (image_height_ff == '0) begin
         last_row_idx = '0;
      end else if (image_height_ff > GEOM_W'(MAX_HEIGHT)) begin
         last_row_idx = GEOM_W'(MAX_HEIGHT - 1);
      end else begin
         last_row_idx = image_height_ff - GEOM_W'(1);
      end
   end

   assign last_col = LW'(col_ff) >= last_col_idx;
   assign last_row = GEOM_W'(row_ff) >= last_row_idx;
   assign odd_col  = col_ff[0];
   assign odd_row  = row_ff[0];
   assign emit     = (odd_col || last_col) && (odd_row || last_row);
   assign first_px = odd_col ? left_ff : req_pixel_in;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + XW'(1);
      end
   end

   // Even rows other than the last go to the bank of their column parity, both at column/2.
   assign pair_addr = AW'(col_ff >> 1);
   assign wr_even   = accept && !odd_row && !last_row && !odd_col;
   assign wr_odd    = accept && !odd_row && !last_row && odd_col;

   bah_line_bank #(.DEPTH(BANK_D), .ADDR_W(AW)) u_bank_even (
      .clock   (clock),
      .wr_en   (wr_even),
      .wr_addr (pair_addr),
      .wr_data (req_pixel_in),
      .rd_en   (accept),
      .rd_addr (pair_addr),
      .rd_data (upper_even)
   );

   bah_line_bank #(.DEPTH(BANK_D), .ADDR_W(AW)) u_bank_odd (
      .clock   (clock),
      .wr_en   (wr_odd),
      .wr_addr (pair_addr),
      .wr_data (req_pixel_in),
      .rd_en   (accept),
      .rd_addr (pair_addr),
      .rd_data (upper_odd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            if (!odd_col) begin
               left_ff <= req_pixel_in;
            end
            s1_valid_ff <= emit;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Payload of stage 1; only loaded on accept, so it holds while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= req_pixel_in;
         s1_first_ff    <= first_px;
         s1_odd_row_ff  <= odd_row;
         s1_odd_col_ff  <= odd_col;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
      end
   end

   // Upper pair: an even last column pairs the even entry with itself.
   assign up_p  = upper_even;
   assign up_q  = s1_odd_col_ff ? upper_odd : upper_even;
   assign avg_p = s1_odd_row_ff ? up_p : s1_first_ff;
   assign avg_q = s1_odd_row_ff ? up_q : s1_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_pixel_ff     <= box4(avg_p, avg_q, s1_first_ff, s1_px_ff);
         out_row_end_ff   <= s1_last_col_ff;
         out_frame_end_ff <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule

// ===== rtl/bah_checker.sv =====
// Port-level checks for the downsampler, bound to the top level.
`timescale 1ns / 1ps

module bah_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bah_pkg::PIXEL_W-1:0] rsp_pixel_out,
   input logic                        rsp_row_end,
   input logic                        rsp_frame_end
);
   import bah_pkg::*;

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The last result of a frame also closes its row.
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   // Input back-pressure only comes from a held result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output free");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("stalled result changed");

endmodule

bind box_average_halve_argb bah_checker u_bah_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_row_end   (rsp_row_end),
   .rsp_frame_end (rsp_frame_end)
);

// ===== tb/box_average_halve_argb_tb.sv =====
// Self-checking testbench for the 2x2 box-average downsampler.
`timescale 1ns / 1ps

module box_average_halve_argb_tb;
   import bah_pkg::*;

   localparam int LINE_W         = MAX_WIDTH_DEF;
   localparam int ROUTINE_PIXELS = 1850;
   localparam int QUIET_TAIL     = 250;
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CUT_PIXELS     = 40;

   typedef logic [GEOM_W-1:0] geom_type;

   typedef struct {
      pixel_type pixel;
      logic      row_end;
      logic      frame_end;
   } mean_result_type;

   class box_mean_scoreboard;
      pixel_type       upper_row [LINE_W];
      pixel_type       left_px;
      int unsigned     col_count;
      int unsigned     row_count;
      geom_type        width_reg;
      geom_type        height_reg;
      mean_result_type expected_means [$];
      int unsigned     errors;

      function new();
         foreach (upper_row[i]) upper_row[i] = '0;
         left_px    = '0;
         col_count  = 0;
         row_count  = 0;
         width_reg  = geom_type'(1);
         height_reg = geom_type'(1);
         errors     = 0;
      endfunction

      function void write_reg(csr_reg_type idx, geom_type val);
         case (idx)
            REG_IMAGE_WIDTH: begin
               width_reg = val;
            end
            REG_IMAGE_HEIGHT: begin
               height_reg = val;
            end
            default: begin
            end
         endcase
      endfunction

      static function pixel_type quad_mean(pixel_type a, pixel_type b, pixel_type c,
                                           pixel_type d);
         pixel_type   mean;
         logic [9:0]  acc;
         mean = '0;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            acc = 10'(a[ch*CHAN_W +: CHAN_W]) + 10'(b[ch*CHAN_W +: CHAN_W])
                + 10'(c[ch*CHAN_W +: CHAN_W]) + 10'(d[ch*CHAN_W +: CHAN_W]) + 10'd2;
            mean[ch*CHAN_W +: CHAN_W] = acc[9:2];
         end
         return mean;
      endfunction

      function bit at_frame_start();
         return col_count == 0 && row_count == 0;
      endfunction

      function void note_pixel(pixel_type px);
         int unsigned     w;
         int unsigned     h;
         int unsigned     x;
         int unsigned     y;
         logic            last_col;
         logic            last_row;
         logic            odd_col;
         logic            odd_row;
         pixel_type       first;
         pixel_type       p;
         pixel_type       q;
         mean_result_type res;
         w = width_reg;
         if (w < 1) w = 1;
         if (w > LINE_W) w = LINE_W;
         h = height_reg;
         if (h < 1) h = 1;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         x = col_count;
         if (x >= LINE_W) x = LINE_W - 1;
         y = row_count;
         last_col = (x >= w - 1);
         last_row = (y >= h - 1);
         odd_col  = x[0];
         odd_row  = y[0];
         first = odd_col ? left_px : px;
         if ((odd_col || last_col) && (odd_row || last_row)) begin
            // an even last row pairs with itself instead of the line store
            if (odd_row) begin
               p = upper_row[x & ~32'd1];
               q = upper_row[x];
            end else begin
               p = first;
               q = px;
            end
            res.pixel     = quad_mean(p, q, first, px);
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            expected_means.push_back(res);
         end
         if (!odd_col) left_px = px;
         if (!odd_row && !last_row) upper_row[x] = px;
         if (last_col) begin
            col_count = 0;
            row_count = last_row ? 0 : y + 1;
         end else begin
            col_count = x + 1;
         end
      endfunction

      function void check_result(pixel_type px, logic row_end, logic frame_end);
         mean_result_type want;
         if (expected_means.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual pixel %h %s %b %s %b",
                     $time, px, "row_end", row_end, "frame_end", frame_end);
            return;
         end
         want = expected_means.pop_front();
         if (px !== want.pixel) begin
            errors++;
            $display("%0t: pixel_out mismatch, expected %h, actual %h", $time, want.pixel, px);
         end
         if (row_end !== want.row_end) begin
            errors++;
            $display("%0t: row_end mismatch, expected %b, actual %b", $time, want.row_end,
                     row_end);
         end
         if (frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end mismatch, expected %b, actual %b", $time, want.frame_end,
                     frame_end);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIXEL_W-1:0]   req_pixel_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIXEL_W-1:0]   rsp_pixel_out;
   logic                 rsp_row_end;
   logic                 rsp_frame_end;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GEOM_W-1:0]    csr_data;

   box_mean_scoreboard means = new();
   bit                 idle_on;
   int unsigned        stall_left;
   int unsigned        pixels_sent;
   int unsigned        quiet_cycles;

   box_average_halve_argb i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic pixel_type rand_pixel();
      pixel_type px;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         case ($urandom_range(0, 5))
            0:       px[ch*CHAN_W +: CHAN_W] = 8'h00;
            1:       px[ch*CHAN_W +: CHAN_W] = 8'hff;
            default: px[ch*CHAN_W +: CHAN_W] = 8'($urandom_range(0, 255));
         endcase
      end
      return px;
   endfunction

   task automatic send_pixel(pixel_type px);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_pixel_in = px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      means.note_pixel(px);
      pixels_sent++;
   endtask

   // Send pixels until the frame position wraps back to the origin.
   task automatic stream_frame();
      do send_pixel(rand_pixel());
      while (!means.at_frame_start());
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (means.expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, geom_type val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      means.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(geom_type w, geom_type h);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   // Receiver back-pressure in short bursts.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         means.check_result(rsp_pixel_out, rsp_row_end, rsp_frame_end);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      pixel_type   corner_block [9];
      int unsigned start_count;
      int unsigned w;
      int unsigned h;
      corner_block = '{32'h0000_0000, 32'hffff_ffff, 32'h0101_0101,
                       32'hffff_ffff, 32'h0000_0000, 32'hfe01_fe01,
                       32'h0000_00ff, 32'hff00_0000, 32'h7f80_7f80};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_pixel_in = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = REG_IMAGE_WIDTH;
      csr_data     = '0;
      idle_on      = 1'b1;
      stall_left   = 0;
      pixels_sent  = 0;
      quiet_cycles = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry is a single pixel, so each pixel is a frame of its own
      send_pixel(32'h0000_0000);
      send_pixel(32'hffff_ffff);
      send_pixel(32'h80ff_017f);
      drain();
      set_geometry(geom_type'(0), geom_type'(0));
      send_pixel(32'h5a3c_c3a5);

      // odd last column and odd last row
      drain();
      set_geometry(geom_type'(3), geom_type'(3));
      foreach (corner_block[i]) send_pixel(corner_block[i]);

      // narrow the frame part way through an odd row, then cut it short
      drain();
      set_geometry(geom_type'(4), geom_type'(5));
      repeat (6) send_pixel(rand_pixel());
      drain();
      write_reg(REG_IMAGE_WIDTH, geom_type'(2));
      send_pixel(rand_pixel());
      drain();
      write_reg(REG_IMAGE_HEIGHT, geom_type'(2));
      repeat (2) send_pixel(rand_pixel());

      // oversize width and height, each cut short by shrinking the geometry
      drain();
      set_geometry('1, geom_type'(0));
      repeat (CUT_PIXELS) send_pixel(rand_pixel());
      drain();
      write_reg(REG_IMAGE_WIDTH, geom_type'(1));
      send_pixel(rand_pixel());
      drain();
      set_geometry(geom_type'(1), '1);
      repeat (CUT_PIXELS) send_pixel(rand_pixel());
      drain();
      write_reg(REG_IMAGE_HEIGHT, geom_type'(1));
      send_pixel(rand_pixel());

      start_count = pixels_sent;
      while (pixels_sent - start_count < ROUTINE_PIXELS) begin
         if (pixels_sent - start_count > ROUTINE_PIXELS - QUIET_TAIL)
            idle_on = 1'b0;
         else
            idle_on = ($urandom_range(0, 3) != 0);
         drain();
         w = $urandom_range(0, 10);
         h = $urandom_range(0, 8);
         set_geometry(geom_type'(w), geom_type'(h));
         if (w >= 2 && h >= 2 && $urandom_range(0, 5) == 0) begin
            // break off inside the second row; narrowing keeps every read written
            repeat (w + $urandom_range(1, w - 1)) send_pixel(rand_pixel());
            drain();
            write_reg(REG_IMAGE_WIDTH, geom_type'($urandom_range(1, w)));
            write_reg(REG_IMAGE_HEIGHT, geom_type'($urandom_range(0, 8)));
         end
         stream_frame();
      end

      drain();
      if (means.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
